FILE: hdl/mpm_pkg.sv
// Package with shared types, register codes and a helper function for the pixel merge.
`timescale 1ns / 1ps
package mpm_pkg;

  // Sample and arithmetic widths.
  localparam int unsigned PixW   = 16;
  localparam int unsigned DiffW  = PixW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned ShiftW = 4;
  localparam int unsigned DepthW = 5;
  localparam int unsigned ModeW  = 2;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = DepthW;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegMaskMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBitDepth = 2'd1;

  // Mask modes. Any other code acts as one sample per pixel.
  localparam logic [ModeW-1:0] ModeQuad   = 2'd0;
  localparam logic [ModeW-1:0] ModePair   = 2'd1;
  localparam logic [ModeW-1:0] ModeSingle = 2'd2;

  // Depth limits and reset values.
  localparam logic [DepthW-1:0] MinDepth   = 5'd10;
  localparam logic [DepthW-1:0] MaxDepth   = 5'd16;
  localparam logic [ShiftW-1:0] WideShift  = 4'd15;
  localparam logic [ModeW-1:0]  ModeReset  = ModeSingle;
  localparam logic [DepthW-1:0] DepthReset = MaxDepth;

  // Stage one result: weight formed, operands prepared.
  typedef struct packed {
    logic [PixW-1:0]          dst;
    logic [PixW-1:0]          src;
    logic signed [DiffW-1:0]  diff;
    logic [PixW-1:0]          mult_op;
    logic [ShiftW-1:0]        shift;
    logic [PixW-1:0]          full;
    logic                     w_zero;
    logic                     w_full;
  } weight_stage_t;

  // Stage two result: product of difference and weight.
  typedef struct packed {
    logic [PixW-1:0]          dst;
    logic [PixW-1:0]          src;
    logic signed [ProdW-1:0]  prod;
    logic [ShiftW-1:0]        shift;
    logic [PixW-1:0]          full;
    logic                     w_zero;
    logic                     w_full;
  } prod_stage_t;

  // Stage three result: unclamped blend sum.
  typedef struct packed {
    logic [PixW-1:0]          dst;
    logic [PixW-1:0]          src;
    logic signed [SumW-1:0]   sum;
    logic [PixW-1:0]          full;
    logic                     w_zero;
    logic                     w_full;
  } sum_stage_t;

  // Rounded average of two samples.
  function automatic logic [PixW-1:0] round_avg(input logic [PixW-1:0] a,
                                                input logic [PixW-1:0] b);
    logic [PixW:0] s;
    s = {1'b0, a} + {1'b0, b} + {{PixW{1'b0}}, 1'b1};
    return s[PixW:1];
  endfunction

endpackage

FILE: hdl/mpm_pix_in_if.sv
// Stream interface for one input transaction: destination, source and four mask samples.
`timescale 1ns / 1ps
interface mpm_pix_in_if;
  logic                        valid;
  logic                        ready;
  logic [mpm_pkg::PixW-1:0]    dst_pixel;
  logic [mpm_pkg::PixW-1:0]    src_pixel;
  logic [mpm_pkg::PixW-1:0]    mask_top_left;
  logic [mpm_pkg::PixW-1:0]    mask_top_right;
  logic [mpm_pkg::PixW-1:0]    mask_bottom_left;
  logic [mpm_pkg::PixW-1:0]    mask_bottom_right;

  modport source (
    output valid, dst_pixel, src_pixel, mask_top_left, mask_top_right,
           mask_bottom_left, mask_bottom_right,
    input  ready
  );

  modport sink (
    input  valid, dst_pixel, src_pixel, mask_top_left, mask_top_right,
           mask_bottom_left, mask_bottom_right,
    output ready
  );
endinterface

FILE: hdl/mpm_pix_out_if.sv
// Stream interface for one output transaction: the merged sample.
`timescale 1ns / 1ps
interface mpm_pix_out_if;
  logic                        valid;
  logic                        ready;
  logic [mpm_pkg::PixW-1:0]    merged_pixel;

  modport source (
    output valid, merged_pixel,
    input  ready
  );

  modport sink (
    input  valid, merged_pixel,
    output ready
  );
endinterface

FILE: hdl/mpm_weight.sv
// First pipeline stage: mask weight forming, depth saturation and operand setup.
`timescale 1ns / 1ps
module mpm_weight (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mpm_pkg::ModeW-1:0]     mask_mode_i,
  input  logic [mpm_pkg::DepthW-1:0]    bit_depth_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [mpm_pkg::PixW-1:0]      dst_i,
  input  logic [mpm_pkg::PixW-1:0]      src_i,
  input  logic [mpm_pkg::PixW-1:0]      tl_i,
  input  logic [mpm_pkg::PixW-1:0]      tr_i,
  input  logic [mpm_pkg::PixW-1:0]      bl_i,
  input  logic [mpm_pkg::PixW-1:0]      br_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output mpm_pkg::weight_stage_t        data_o
);

  logic [mpm_pkg::DepthW-1:0] depth;
  logic [mpm_pkg::PixW:0]     full_wide;
  logic [mpm_pkg::PixW-1:0]   weight;
  logic                       is_wide;
  mpm_pkg::weight_stage_t     data_d;
  mpm_pkg::weight_stage_t     data_q;
  logic                       valid_q;

  // Saturate the depth into the supported range.
  always_comb begin
    if (bit_depth_i < mpm_pkg::MinDepth) begin
      depth = mpm_pkg::MinDepth;
    end else if (bit_depth_i > mpm_pkg::MaxDepth) begin
      depth = mpm_pkg::MaxDepth;
    end else begin
      depth = bit_depth_i;
    end
  end

  assign full_wide = ({{mpm_pkg::PixW{1'b0}}, 1'b1} << depth) - {{mpm_pkg::PixW{1'b0}}, 1'b1};
  assign is_wide   = (depth == mpm_pkg::MaxDepth);

  // Weight from one, two or four mask samples.
  always_comb begin
    case (mask_mode_i)
      mpm_pkg::ModeQuad: begin
        weight = mpm_pkg::round_avg(mpm_pkg::round_avg(tl_i, bl_i),
                                    mpm_pkg::round_avg(tr_i, br_i));
      end
      mpm_pkg::ModePair: begin
        weight = mpm_pkg::round_avg(tl_i, tr_i);
      end
      default: begin
        weight = tl_i;
      end
    endcase
  end

  // At full depth the weight drops one bit so the product keeps its range.
  always_comb begin
    data_d.dst     = dst_i;
    data_d.src     = src_i;
    data_d.diff    = $signed({1'b0, src_i}) - $signed({1'b0, dst_i});
    data_d.mult_op = is_wide ? {1'b0, weight[mpm_pkg::PixW-1:1]} : weight;
    data_d.shift   = is_wide ? mpm_pkg::WideShift : depth[mpm_pkg::ShiftW-1:0];
    data_d.full    = full_wide[mpm_pkg::PixW-1:0];
    data_d.w_zero  = (weight == '0);
    data_d.w_full  = (weight == full_wide[mpm_pkg::PixW-1:0]);
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // A weight cannot be both zero and full scale, since full scale is never zero.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $onehot0({data_q.w_zero, data_q.w_full}))
    else $error("weight flags both set");

  // The shift amount stays within the saturated depth range.
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.shift >= mpm_pkg::MinDepth[mpm_pkg::ShiftW-1:0]))
    else $error("shift below minimum depth");

endmodule

FILE: hdl/mpm_mult.sv
// Second pipeline stage: signed product of the sample difference and the weight.
`timescale 1ns / 1ps
module mpm_mult (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  mpm_pkg::weight_stage_t  data_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output mpm_pkg::prod_stage_t    data_o
);

  mpm_pkg::prod_stage_t data_d;
  mpm_pkg::prod_stage_t data_q;
  logic                 valid_q;

  // One 17 by 17 signed multiply.
  always_comb begin
    data_d.dst    = data_i.dst;
    data_d.src    = data_i.src;
    data_d.prod   = data_i.diff * $signed({1'b0, data_i.mult_op});
    data_d.shift  = data_i.shift;
    data_d.full   = data_i.full;
    data_d.w_zero = data_i.w_zero;
    data_d.w_full = data_i.w_full;
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/mpm_blend.sv
// Third and fourth pipeline stages: floor shift and add, then clamp and select.
`timescale 1ns / 1ps
module mpm_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  mpm_pkg::prod_stage_t        data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [mpm_pkg::PixW-1:0]    pixel_o
);

  logic signed [mpm_pkg::ProdW-1:0] shifted;
  mpm_pkg::sum_stage_t              sum_d;
  mpm_pkg::sum_stage_t              sum_q;
  logic                             sum_valid_q;
  logic                             sum_ready;
  logic [mpm_pkg::PixW-1:0]         pixel_d;
  logic [mpm_pkg::PixW-1:0]         pixel_q;
  logic                             out_valid_q;
  logic                             out_is_blend_q;
  logic [mpm_pkg::PixW-1:0]         out_full_q;

  // Arithmetic shift rounds toward minus infinity.
  assign shifted = data_i.prod >>> data_i.shift;

  always_comb begin
    sum_d.dst    = data_i.dst;
    sum_d.src    = data_i.src;
    sum_d.sum    = $signed({{(mpm_pkg::SumW-mpm_pkg::PixW){1'b0}}, data_i.dst})
                 + $signed({shifted[mpm_pkg::ProdW-1], shifted});
    sum_d.full   = data_i.full;
    sum_d.w_zero = data_i.w_zero;
    sum_d.w_full = data_i.w_full;
  end

  assign ready_o   = !sum_valid_q || sum_ready;
  assign sum_ready = !out_valid_q || ready_i;

  // Sum stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (ready_o) begin
      sum_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sum_q <= sum_d;
    end
  end

  // Pass-through for extreme weights, otherwise clamp to zero and full scale.
  always_comb begin
    if (sum_q.w_zero) begin
      pixel_d = sum_q.dst;
    end else if (sum_q.w_full) begin
      pixel_d = sum_q.src;
    end else if (sum_q.sum < 0) begin
      pixel_d = '0;
    end else if (sum_q.sum > $signed({{(mpm_pkg::SumW-mpm_pkg::PixW){1'b0}}, sum_q.full})) begin
      pixel_d = sum_q.full;
    end else begin
      pixel_d = sum_q.sum[mpm_pkg::PixW-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_ready) begin
      out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_valid_q && sum_ready) begin
      pixel_q        <= pixel_d;
      out_is_blend_q <= !sum_q.w_zero && !sum_q.w_full;
      out_full_q     <= sum_q.full;
    end
  end

  assign valid_o = out_valid_q;
  assign pixel_o = pixel_q;

  // A blended result never exceeds full scale of its depth.
  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_is_blend_q) |-> (pixel_q <= out_full_q))
    else $error("blended pixel above full scale");

  // A stalled sum stage keeps its transaction until the output register frees up.
  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_valid_q && !sum_ready) |=> (sum_valid_q && $stable(sum_q)))
    else $error("sum stage lost a stalled transaction");

  // A full sum stage only takes data while its downstream side can move.
  a_sum_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ready_i && sum_valid_q) |-> !ready_o)
    else $error("sum stage accepted while full and stalled");

endmodule

FILE: hdl/masked_pixel_merge.sv
// Top level of the masked pixel merge: configuration registers and the four-stage pipeline.
`timescale 1ns / 1ps
// The block blends a destination sample toward a source sample by a mask weight,
// one pixel per clock while the output is not stalled. Each transaction passes
// four register stages (weight forming, multiply, shift and add, clamp into the
// output register). The rate is one transaction per cycle, since every stage can
// accept in the cycle in which its successor moves. Registers: index 0 mask_mode
// (0 = 4:2:0, 1 = 4:2:2, 2 or 3 = 4:4:4), index 1 bit_depth (saturated to 10..16);
// write them only while the pipeline is empty.
module masked_pixel_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mpm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mpm_pkg::CfgDataW-1:0]    cfg_wdata_i,
  mpm_pix_in_if.sink                      pix_in,
  mpm_pix_out_if.source                   pix_out
);

  logic [mpm_pkg::ModeW-1:0]  mask_mode_q;
  logic [mpm_pkg::DepthW-1:0] bit_depth_q;

  logic                       w_valid;
  logic                       w_ready;
  mpm_pkg::weight_stage_t     w_data;
  logic                       p_valid;
  logic                       p_ready;
  mpm_pkg::prod_stage_t       p_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_mode_q <= mpm_pkg::ModeReset;
      bit_depth_q <= mpm_pkg::DepthReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpm_pkg::RegMaskMode: mask_mode_q <= cfg_wdata_i[mpm_pkg::ModeW-1:0];
        mpm_pkg::RegBitDepth: bit_depth_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Weight stage.
  mpm_weight u_weight (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mask_mode_i (mask_mode_q),
    .bit_depth_i (bit_depth_q),
    .valid_i     (pix_in.valid),
    .ready_o     (pix_in.ready),
    .dst_i       (pix_in.dst_pixel),
    .src_i       (pix_in.src_pixel),
    .tl_i        (pix_in.mask_top_left),
    .tr_i        (pix_in.mask_top_right),
    .bl_i        (pix_in.mask_bottom_left),
    .br_i        (pix_in.mask_bottom_right),
    .valid_o     (w_valid),
    .ready_i     (w_ready),
    .data_o      (w_data)
  );

  // Multiply stage.
  mpm_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (w_valid),
    .ready_o (w_ready),
    .data_i  (w_data),
    .valid_o (p_valid),
    .ready_i (p_ready),
    .data_o  (p_data)
  );

  // Shift, add and clamp stages.
  mpm_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_valid),
    .ready_o (p_ready),
    .data_i  (p_data),
    .valid_o (pix_out.valid),
    .ready_i (pix_out.ready),
    .pixel_o (pix_out.merged_pixel)
  );

endmodule

FILE: verif/mpm_merge_checker.sv
// Scoreboard for the masked pixel merge: predicts each merged sample and checks the output stream.
`timescale 1ns / 1ps
module mpm_merge_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpm_pkg::CfgDataW-1:0] cfg_wdata_i,
  mpm_pix_in_if                        pix_in,
  mpm_pix_out_if                       pix_out,
  output int                           mismatch_count_o,
  output int                           pending_count_o,
  output int                           checked_count_o
);

  typedef struct {
    logic [mpm_pkg::PixW-1:0] merged;
    int unsigned              seq;
  } merged_expect_t;

  merged_expect_t             merged_expect_q[$];
  logic [mpm_pkg::ModeW-1:0]  shadow_mode  = mpm_pkg::ModeReset;
  logic [mpm_pkg::DepthW-1:0] shadow_depth = mpm_pkg::DepthReset;
  int unsigned                accepted_count = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count_o++;
  endtask

  // Rounded-up mean of two unsigned samples.
  function automatic int unsigned mean_up(input int unsigned a, input int unsigned b);
    return (a + b + 1) >> 1;
  endfunction

  // Expected merged sample for one input transaction under the given settings.
  function automatic logic [mpm_pkg::PixW-1:0] blend_pixel(
    input logic [mpm_pkg::ModeW-1:0]  mode,
    input logic [mpm_pkg::DepthW-1:0] depth_reg,
    input logic [mpm_pkg::PixW-1:0]   dst,
    input logic [mpm_pkg::PixW-1:0]   src,
    input logic [mpm_pkg::PixW-1:0]   tl,
    input logic [mpm_pkg::PixW-1:0]   tr,
    input logic [mpm_pkg::PixW-1:0]   bl,
    input logic [mpm_pkg::PixW-1:0]   br
  );
    int unsigned depth;
    longint      full;
    longint      weight;
    longint      diff;
    longint      acc;
    depth = depth_reg;
    if (depth < mpm_pkg::MinDepth) depth = mpm_pkg::MinDepth;
    if (depth > mpm_pkg::MaxDepth) depth = mpm_pkg::MaxDepth;
    full = (longint'(1) << depth) - 1;

    case (mode)
      mpm_pkg::ModeQuad: weight = mean_up(mean_up(tl, bl), mean_up(tr, br));
      mpm_pkg::ModePair: weight = mean_up(tl, tr);
      default:           weight = tl;
    endcase

    // The two end weights pass a sample through untouched, even above full scale.
    if (weight == 0) begin
      acc = dst;
    end else if (weight == full) begin
      acc = src;
    end else begin
      diff = longint'(src) - longint'(dst);
      // Arithmetic shifts of signed values round toward minus infinity.
      if (depth < mpm_pkg::MaxDepth) begin
        acc = longint'(dst) + ((diff * weight) >>> depth);
      end else begin
        acc = longint'(dst) + ((diff * (weight >> 1)) >>> mpm_pkg::WideShift);
      end
      if (acc < 0) acc = 0;
      if (acc > full) acc = full;
    end
    return acc[mpm_pkg::PixW-1:0];
  endfunction

  // Compare results, queue predictions and follow register writes, in that order.
  always @(posedge clk_i or negedge rst_ni) begin
    merged_expect_t head;
    if (!rst_ni) begin
      shadow_mode  = mpm_pkg::ModeReset;
      shadow_depth = mpm_pkg::DepthReset;
      merged_expect_q.delete();
      pending_count_o = 0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (merged_expect_q.size() == 0) begin
          report_mismatch($sformatf("merged_pixel 0x%04h with no transaction outstanding",
                                    pix_out.merged_pixel));
        end else begin
          head = merged_expect_q.pop_front();
          checked_count_o++;
          if (pix_out.merged_pixel !== head.merged) begin
            report_mismatch($sformatf("pixel %0d: merged_pixel 0x%04h, expected 0x%04h",
                                      head.seq, pix_out.merged_pixel, head.merged));
          end
        end
      end

      if (pix_in.valid && pix_in.ready) begin
        head.merged = blend_pixel(shadow_mode, shadow_depth, pix_in.dst_pixel,
                                  pix_in.src_pixel, pix_in.mask_top_left,
                                  pix_in.mask_top_right, pix_in.mask_bottom_left,
                                  pix_in.mask_bottom_right);
        head.seq = accepted_count;
        accepted_count++;
        merged_expect_q.push_back(head);
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          mpm_pkg::RegMaskMode: shadow_mode  = cfg_wdata_i[mpm_pkg::ModeW-1:0];
          mpm_pkg::RegBitDepth: shadow_depth = cfg_wdata_i[mpm_pkg::DepthW-1:0];
          default: ;
        endcase
      end

      pending_count_o = merged_expect_q.size();
    end
  end

endmodule

FILE: verif/tb_masked_pixel_merge.sv
// Testbench top for the masked pixel merge: clock, reset, stimulus, settings and verdict.
`timescale 1ns / 1ps
module tb_masked_pixel_merge;

  localparam int     ClkPeriodNs    = 12;
  localparam int     ResetCycles    = 8;
  localparam int     RandomPhases   = 12;
  localparam int     PixelsPerPhase = 140;
  localparam int     IdlePercent    = 23;
  localparam int     LongHold       = 64;
  localparam int     SettleCycles   = 8;
  localparam longint WatchdogNs     = 2_000_000;

  typedef logic [mpm_pkg::PixW-1:0]     sample_t;
  typedef logic [mpm_pkg::ModeW-1:0]    mode_t;
  typedef logic [mpm_pkg::DepthW-1:0]   depth_t;
  typedef logic [mpm_pkg::CfgDataW-1:0] cfg_data_t;

  // Unassigned mode code; the block treats it as one sample per pixel.
  localparam mode_t ModeAlias = 2'd3;

  typedef struct packed {
    sample_t dst, src, tl, tr, bl, br;
  } pix_item_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [mpm_pkg::CfgIdxW-1:0]  cfg_idx;
  cfg_data_t                    cfg_wdata;

  bit          calm;
  bit          out_hold_req;
  bit          hold_done;
  int          hold_left;
  int          settings_count;
  int unsigned cur_full;
  int          mismatch_count;
  int          pending_count;
  int          checked_count;

  mpm_pix_in_if  pix_in_if ();
  mpm_pix_out_if pix_out_if ();

  masked_pixel_merge u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_in      (pix_in_if),
    .pix_out     (pix_out_if)
  );

  mpm_merge_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .pix_in           (pix_in_if),
    .pix_out          (pix_out_if),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriodNs / 2) clk_i = ~clk_i;
  end

  // Random idle decision shared by both sides; never idles during a calm stretch.
  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < IdlePercent);
  endfunction

  function automatic int unsigned depth_full(input depth_t depth);
    int unsigned d;
    d = depth;
    if (d < mpm_pkg::MinDepth) d = mpm_pkg::MinDepth;
    if (d > mpm_pkg::MaxDepth) d = mpm_pkg::MaxDepth;
    return (1 << d) - 1;
  endfunction

  function automatic pix_item_t pix(input sample_t dst, src, tl, tr, bl, br);
    pix_item_t it;
    it.dst = dst;
    it.src = src;
    it.tl  = tl;
    it.tr  = tr;
    it.bl  = bl;
    it.br  = br;
    return it;
  endfunction

  // Mostly in range for the current depth, with ends and out-of-range values mixed in.
  function automatic sample_t pick_sample(input int unsigned full);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return sample_t'($urandom);
    if (roll < 15) return '0;
    if (roll < 20) return sample_t'(full);
    return sample_t'($urandom_range(0, full));
  endfunction

  // Mask shapes are chosen so that zero, full-scale and near-full weights occur in every mode.
  function automatic pix_item_t make_random_pixel(input int unsigned full);
    pix_item_t   it;
    int unsigned roll;
    sample_t     level;
    it.dst = pick_sample(full);
    it.src = pick_sample(full);
    level  = pick_sample(full);
    roll   = $urandom_range(0, 99);
    if (roll < 10) begin
      it.tl = '0; it.tr = '0; it.bl = '0; it.br = '0;
    end else if (roll < 20) begin
      it.tl = sample_t'(full); it.tr = sample_t'(full);
      it.bl = sample_t'(full); it.br = sample_t'(full);
    end else if (roll < 30) begin
      it.tl = sample_t'($urandom_range(full - 1, full));
      it.tr = sample_t'($urandom_range(full - 1, full));
      it.bl = sample_t'($urandom_range(full - 1, full));
      it.br = sample_t'($urandom_range(full - 1, full));
    end else if (roll < 40) begin
      it.tl = level; it.tr = level; it.bl = level; it.br = level;
    end else if (roll < 50) begin
      it.tl = sample_t'($urandom); it.tr = sample_t'($urandom);
      it.bl = sample_t'($urandom); it.br = sample_t'($urandom);
    end else begin
      it.tl = pick_sample(full); it.tr = pick_sample(full);
      it.bl = pick_sample(full); it.br = pick_sample(full);
    end
    return it;
  endfunction

  // Offer one input transaction; returns at the falling edge after it is accepted.
  task automatic send_pixel(input pix_item_t it);
    while (idle_now()) begin
      pix_in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_in_if.valid             <= 1'b1;
    pix_in_if.dst_pixel         <= it.dst;
    pix_in_if.src_pixel         <= it.src;
    pix_in_if.mask_top_left     <= it.tl;
    pix_in_if.mask_top_right    <= it.tr;
    pix_in_if.mask_bottom_left  <= it.bl;
    pix_in_if.mask_bottom_right <= it.br;
    @(posedge clk_i);
    while (!pix_in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic wait_drained();
    pix_in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
  endtask

  // Write both registers while the pipeline is empty.
  task automatic apply_settings(input mode_t mode, input depth_t depth);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= mpm_pkg::RegMaskMode;
    cfg_wdata <= cfg_data_t'(mode);
    @(negedge clk_i);
    cfg_idx   <= mpm_pkg::RegBitDepth;
    cfg_wdata <= cfg_data_t'(depth);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cur_full = depth_full(depth);
    settings_count++;
  endtask

  // Output side: random back-pressure, plus one long hold-off counted here.
  initial begin
    pix_out_if.ready <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    @(negedge clk_i);
    forever begin
      if (out_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out_if.ready <= 1'b0;
      end else begin
        pix_out_if.ready <= !idle_now();
      end
      @(negedge clk_i);
    end
  end

  // Stimulus: reset, directed corner cases, then randomized phases under several settings.
  initial begin
    pix_in_if.valid             <= 1'b0;
    pix_in_if.dst_pixel         <= '0;
    pix_in_if.src_pixel         <= '0;
    pix_in_if.mask_top_left     <= '0;
    pix_in_if.mask_top_right    <= '0;
    pix_in_if.mask_bottom_left  <= '0;
    pix_in_if.mask_bottom_right <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= mpm_pkg::RegMaskMode;
    cfg_wdata <= '0;
    rst_ni    <= 1'b0;
    calm = 1'b0;
    out_hold_req = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    cur_full = depth_full(mpm_pkg::DepthReset);
    settings_count = 1;

    // Reset settings, one sample at 16 bits: end weights, off-by-one weights, wide shift.
    send_pixel(pix(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pix(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(pix(16'h0000, 16'hFFFF, 16'h0001, 16'h1234, 16'h0000, 16'hFFFF));
    send_pixel(pix(16'hFFFF, 16'h0000, 16'hFFFE, 16'h0000, 16'h5555, 16'h0000));
    send_pixel(pix(16'h1234, 16'hABCD, 16'h8000, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(pix(16'hFFFF, 16'hFFFF, 16'h0001, 16'hAAAA, 16'h0000, 16'h0000));

    // Pair of samples at 10 bits: samples and weights above full scale, pass-through ends.
    apply_settings(mpm_pkg::ModePair, mpm_pkg::MinDepth);
    send_pixel(pix(16'h0000, 16'h03FF, 16'h03FF, 16'h03FF, 16'h0000, 16'h0000));
    send_pixel(pix(16'hFFFF, 16'h0100, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_pixel(pix(16'hEA60, 16'h0000, 16'h0200, 16'h01FF, 16'h0000, 16'h0000));
    send_pixel(pix(16'h0000, 16'h03FF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
    send_pixel(pix(16'h8000, 16'h8000, 16'h0001, 16'h0002, 16'h0000, 16'h0000));

    // Quad of samples at 12 bits: zero, full and smallest nonzero quad averages.
    apply_settings(mpm_pkg::ModeQuad, 5'd12);
    send_pixel(pix(16'h0000, 16'h0FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(pix(16'h0FFF, 16'h0000, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF));
    send_pixel(pix(16'h0000, 16'h0FFF, 16'h0000, 16'h0000, 16'h0001, 16'h0000));
    send_pixel(pix(16'h0100, 16'h0F00, 16'h0FFF, 16'h0000, 16'h0FFE, 16'h0001));

    // Unassigned mode code with a depth below range, which saturates to 10 bits.
    apply_settings(ModeAlias, 5'd0);
    send_pixel(pix(16'h0000, 16'h03FF, 16'h03FF, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(pix(16'h03FF, 16'h0000, 16'h0155, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(pix(16'h0000, 16'hFFFF, 16'h0200, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    // Depth above range saturates to 16 bits.
    apply_settings(mpm_pkg::ModeSingle, 5'd31);
    send_pixel(pix(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(pix(16'hFFFF, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000));

    apply_settings(mpm_pkg::ModePair, 5'd14);
    send_pixel(pix(16'h3FFF, 16'h0000, 16'h3FFF, 16'h3FFE, 16'h0000, 16'h0000));
    send_pixel(pix(16'h0000, 16'h3FFF, 16'h0001, 16'h0000, 16'h0000, 16'h0000));

    // Randomized phases: fixed corner settings first, then random ones.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      mode_t  mode;
      depth_t depth;
      case (ph)
        0: begin mode = mpm_pkg::ModeQuad;   depth = mpm_pkg::MinDepth;  end
        1: begin mode = mpm_pkg::ModePair;   depth = mpm_pkg::MaxDepth;  end
        2: begin mode = mpm_pkg::ModeSingle; depth = mpm_pkg::MinDepth;  end
        3: begin mode = mpm_pkg::ModeQuad;   depth = mpm_pkg::MaxDepth;  end
        4: begin mode = mpm_pkg::ModePair;   depth = 5'd12;              end
        5: begin mode = ModeAlias;           depth = 5'd3;               end
        6: begin mode = mpm_pkg::ModeSingle; depth = 5'd14;              end
        7: begin mode = mpm_pkg::ModeQuad;   depth = 5'd31;              end
        default: begin
          mode = mode_t'($urandom_range(0, 3));
          if ($urandom_range(0, 99) < 75) begin
            depth = mpm_pkg::MinDepth + depth_t'(2 * $urandom_range(0, 3));
          end else begin
            depth = depth_t'($urandom_range(0, 31));
          end
        end
      endcase
      apply_settings(mode, depth);
      // One phase runs without any idling on either side.
      calm = (ph == 2);
      for (int n = 0; n < PixelsPerPhase; n++) begin
        if (ph == 4 && n == 20) out_hold_req = 1'b1;
        if (ph == 6 && n == 70) wait_drained();
        send_pixel(make_random_pixel(cur_full));
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    $display("Summary: %0d merged pixels checked over %0d register settings", checked_count,
             settings_count);
    $display("Summary: all mask modes, depths 10-16 with saturation, long output hold, drain");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(WatchdogNs);
    $display("Timeout: %0d results still outstanding", pending_count);
    $display("== FAIL ==");
    $finish;
  end

endmodule
